// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on i_clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition must never be seen out of reset
`define ASSERT_NEVER(name, cond, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

// ===== rtl/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Widths, operation codes and beat types of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fpa_pkg;

    localparam int W        = 32;
    localparam int F        = 8;
    localparam int DIV_BITS = W + F;
    localparam int MAG_W    = (2 * W - F > W + F) ? (2 * W - F + 1) : (W + F + 1);

    localparam logic [2*W:0] HALF = (F == 0) ? '0 : ((2 * W + 1)'(1) << (F - 1));
    localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

    localparam logic [3:0] KIND_ADD      = 4'd0;
    localparam logic [3:0] KIND_SUB      = 4'd1;
    localparam logic [3:0] KIND_MUL      = 4'd2;
    localparam logic [3:0] KIND_DIV      = 4'd3;
    localparam logic [3:0] KIND_MIN      = 4'd4;
    localparam logic [3:0] KIND_MAX      = 4'd5;
    localparam logic [3:0] KIND_INC      = 4'd6;
    localparam logic [3:0] KIND_DEC      = 4'd7;
    localparam logic [3:0] KIND_TO_INT   = 4'd8;
    localparam logic [3:0] KIND_FROM_INT = 4'd9;

    typedef struct packed {
        logic [3:0]          kind;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic signed [W-1:0] value;
        logic                a_less;
        logic                a_equal;
        logic                a_greater;
        logic                divide_by_zero;
        logic                saturated;
    } t_out_beat;

    typedef struct packed {
        logic [3:0]     kind;
        logic           lt;
        logic           eq;
        logic           gt;
        logic [W-1:0]   simple_val;
        logic           simple_sat;
        logic           neg;
        logic           dbz;
        logic [W-1:0]   mag_a;
        logic [W-1:0]   divisor;
        logic [2*W-1:0] prod;
    } t_op;

    typedef struct packed {
        logic [W-1:0]        rem;
        logic [DIV_BITS-1:0] dq;
    } t_div;

endpackage

// ===== rtl/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// Input register and decode stage: compares, add/sub/min/max/inc/dec,
// conversion to integer and operand magnitudes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_front import fpa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  logic     i_valid,
    input  t_in_beat i_data,
    output logic     o_valid,
    output t_op      o_op
);

    logic     r_valid_in;
    t_in_beat r_in;
    logic     r_valid_op;
    t_op      r_op;
    t_op      n_op;

    function automatic logic [W:0] add_sat(input logic [W-1:0] a, input logic [W-1:0] b,
                                           input logic sub);
        logic [W:0] s;
        logic       ovf;
        s   = sub ? ({a[W-1], a} - {b[W-1], b}) : ({a[W-1], a} + {b[W-1], b});
        ovf = s[W] != s[W-1];
        return {ovf, ovf ? (a[W-1] ? WMIN : WMAX) : s[W-1:0]};
    endfunction

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_in <= 1'b0;
            r_valid_op <= 1'b0;
        end else if (i_en) begin
            r_valid_in <= i_valid;
            r_valid_op <= r_valid_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in <= i_data;
            r_op <= n_op;
        end
    end

    always_comb begin
        logic [W:0] res;
        res              = '0;
        n_op             = '0;
        n_op.kind        = r_in.kind;
        n_op.lt          = r_in.operand_a < r_in.operand_b;
        n_op.eq          = r_in.operand_a == r_in.operand_b;
        n_op.gt          = r_in.operand_a > r_in.operand_b;
        n_op.mag_a       = mag(r_in.operand_a);
        n_op.divisor     = mag(r_in.operand_b);
        n_op.neg         = (r_in.kind == KIND_FROM_INT) ? r_in.operand_a[W-1]
                         : (r_in.operand_a[W-1] ^ r_in.operand_b[W-1]);
        n_op.dbz         = (r_in.kind == KIND_DIV) && (r_in.operand_b == '0);
        unique case (r_in.kind)
            KIND_ADD:    res = add_sat(r_in.operand_a, r_in.operand_b, 1'b0);
            KIND_SUB:    res = add_sat(r_in.operand_a, r_in.operand_b, 1'b1);
            KIND_INC:    res = add_sat(r_in.operand_a, W'(1), 1'b0);
            KIND_DEC:    res = add_sat(r_in.operand_a, W'(1), 1'b1);
            KIND_MIN:    res = {1'b0, n_op.gt ? r_in.operand_b : r_in.operand_a};
            KIND_MAX:    res = {1'b0, n_op.lt ? r_in.operand_b : r_in.operand_a};
            KIND_TO_INT: res = {1'b0, W'(r_in.operand_a >>> F)};
            default:     res = '0;
        endcase
        n_op.simple_sat = res[W];
        n_op.simple_val = res[W-1:0];
    end

    assign o_valid = r_valid_op;
    assign o_op    = r_op;

endmodule

// ===== rtl/fpa_div_step.sv =====
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring-division stage: one quotient bit per register stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fpa_div_step import fpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  logic i_valid,
    input  t_op  i_op,
    input  t_div i_div,
    output logic o_valid,
    output t_op  o_op,
    output t_div o_div
);

    logic       r_valid;
    t_op        r_op;
    t_div       r_div;
    t_div       n_div;
    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    assign trial = {i_div.rem, i_div.dq[DIV_BITS-1]};
    assign diff  = trial - {1'b0, i_op.divisor};
    assign ge    = trial >= {1'b0, i_op.divisor};

    always_comb begin
        n_div.rem = ge ? diff[W-1:0] : trial[W-1:0];
        n_div.dq  = {i_div.dq[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op  <= i_op;
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_op    = r_op;
    assign o_div   = r_div;

endmodule

// ===== rtl/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// Rounding stage for multiply and divide, scaling for from-integer conversion,
// then saturation, result select and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module fpa_back import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_op       i_op,
    input  t_div      i_div,
    output logic      o_valid,
    output t_out_beat o_data
);

    logic             r_valid_rnd;
    t_op              r_op;
    logic [MAG_W-1:0] r_mag;
    logic [MAG_W-1:0] n_mag;
    logic             r_valid_out;
    t_out_beat        r_out;
    t_out_beat        n_out;

    always_comb begin
        logic [2*W:0]      mul_sum;
        logic [DIV_BITS:0] div_q;
        logic              up;
        mul_sum = {1'b0, i_op.prod} + HALF;
        up      = {i_div.rem, 1'b0} >= {1'b0, i_op.divisor};
        div_q   = {1'b0, i_div.dq} + (DIV_BITS + 1)'(up);
        case (i_op.kind)
            KIND_MUL:      n_mag = MAG_W'(mul_sum >> F);
            KIND_DIV:      n_mag = MAG_W'(div_q);
            KIND_FROM_INT: n_mag = MAG_W'(i_op.mag_a) << F;
            default:       n_mag = '0;
        endcase
    end

    always_comb begin
        logic [MAG_W-1:0] limit;
        logic [MAG_W-1:0] m;
        logic             sat;
        limit = r_op.neg ? MAG_W'(WMIN) : MAG_W'(WMAX);
        sat   = r_mag > limit;
        m     = sat ? limit : r_mag;
        n_out.a_less         = r_op.lt;
        n_out.a_equal        = r_op.eq;
        n_out.a_greater      = r_op.gt;
        n_out.divide_by_zero = r_op.dbz;
        unique case (r_op.kind) inside
            KIND_MUL, KIND_DIV, KIND_FROM_INT: begin
                n_out.value     = r_op.neg ? (~m[W-1:0] + W'(1)) : m[W-1:0];
                n_out.saturated = sat;
            end
            default: begin
                n_out.value     = r_op.simple_val;
                n_out.saturated = r_op.simple_sat;
            end
        endcase
        if (r_op.dbz) begin
            n_out.value     = '0;
            n_out.saturated = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_rnd <= 1'b0;
            r_valid_out <= 1'b0;
        end else if (i_en) begin
            r_valid_rnd <= i_valid;
            r_valid_out <= r_valid_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_op  <= i_op;
            r_mag <= n_mag;
            r_out <= n_out;
        end
    end

    assign o_valid = r_valid_out;
    assign o_data  = r_out;

    `ASSERT_CLK(a_cmp_onehot, !r_valid_out ||
        $onehot({r_out.a_less, r_out.a_equal, r_out.a_greater}), "compare bits not one-hot")
    `ASSERT_CLK(a_dbz_zero, (r_valid_out && r_out.divide_by_zero) |->
        (r_out.value == '0 && !r_out.saturated), "divide by zero result not zero")
    `ASSERT_CLK(a_sat_limit, (r_valid_out && r_out.saturated) |->
        (r_out.value == WMAX || r_out.value == WMIN), "saturated value off the limits")

endmodule

// ===== rtl/fixed_point_alu_q24_8_core.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_core
// Pipelined Q24.8 fixed-point ALU: add, sub, mul, div, min, max, inc, dec,
// integer conversion, with saturation and operand compare.
//
//   channel | valid   | stall   | beat
//   --------+---------+---------+---------------------------
//   in      | i_valid | o_stall | i_data  (kind, operands)
//   out     | o_valid | i_stall | o_data  (value, flags)
//
// One beat accepted per cycle unless i_stall holds an output beat. The core
// has 40 divider stages, one quotient bit each, plus 2 front, 1 multiply and
// 2 rounding/output stages. Reset is synchronous and clears valid bits only.
// An output beat held by i_stall freezes the whole pipeline in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_point_alu_q24_8_core import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_beat  i_data,
    output logic      o_stall,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);

    logic en;
    logic front_valid;
    t_op  front_op;
    logic r_mul_valid;
    t_op  r_mul_op;
    t_op  n_mul_op;
    t_div r_mul_div;
    t_div n_mul_div;
    logic w_valid [0:DIV_BITS];
    t_op  w_op    [0:DIV_BITS];
    t_div w_div   [0:DIV_BITS];

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    fpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (front_valid),
        .o_op    (front_op)
    );

    always_comb begin
        n_mul_op      = front_op;
        n_mul_op.prod = (2 * W)'(front_op.mag_a) * (2 * W)'(front_op.divisor);
        n_mul_div.rem = '0;
        n_mul_div.dq  = DIV_BITS'(front_op.mag_a) << F;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else if (en) begin
            r_mul_valid <= front_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mul_op  <= n_mul_op;
            r_mul_div <= n_mul_div;
        end
    end

    assign w_valid[0] = r_mul_valid;
    assign w_op[0]    = r_mul_op;
    assign w_div[0]   = r_mul_div;

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
        fpa_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (w_valid[g]),
            .i_op    (w_op[g]),
            .i_div   (w_div[g]),
            .o_valid (w_valid[g+1]),
            .o_op    (w_op[g+1]),
            .o_div   (w_div[g+1])
        );
    end

    fpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (w_valid[DIV_BITS]),
        .i_op    (w_op[DIV_BITS]),
        .i_div   (w_div[DIV_BITS]),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// Q24.8 fixed-point ALU testbench
// Drives operation beats through the core with random gaps and output stalls,
// predicts every result with an exact integer model and checks each one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class alu_scoreboard;
    fpa_pkg::t_out_beat pending[$];
    int errors;
    int checked;

    function fpa_pkg::t_out_beat compute(fpa_pkg::t_in_beat b);
        fpa_pkg::t_out_beat r;
        longint sa, sb, s;
        logic [127:0] am, bm, p, q, rm;
        logic neg;
        sa = longint'(b.operand_a);
        sb = longint'(b.operand_b);
        r = '0;
        r.a_less = sa < sb;
        r.a_equal = sa == sb;
        r.a_greater = sa > sb;
        am = (sa < 0) ? 128'(-sa) : 128'(sa);
        bm = (sb < 0) ? 128'(-sb) : 128'(sb);
        neg = (sa < 0) != (sb < 0);
        p = '0;
        case (b.kind)
            fpa_pkg::KIND_ADD: s = sa + sb;
            fpa_pkg::KIND_SUB: s = sa - sb;
            fpa_pkg::KIND_INC: s = sa + 1;
            fpa_pkg::KIND_DEC: s = sa - 1;
            fpa_pkg::KIND_MIN: s = (sa > sb) ? sb : sa;
            fpa_pkg::KIND_MAX: s = (sa < sb) ? sb : sa;
            fpa_pkg::KIND_TO_INT: s = sa >>> fpa_pkg::F;
            fpa_pkg::KIND_FROM_INT: s = sa * (64'sd1 << fpa_pkg::F);
            fpa_pkg::KIND_MUL: begin
                p = (am * bm + (128'd1 << (fpa_pkg::F - 1))) >> fpa_pkg::F;
                s = 0;
            end
            fpa_pkg::KIND_DIV: begin
                s = 0;
                if (sb == 0) begin
                    r.divide_by_zero = 1'b1;
                end else begin
                    q = (am << fpa_pkg::F) / bm;
                    rm = (am << fpa_pkg::F) % bm;
                    p = (rm >= bm - rm) ? q + 1 : q;
                end
            end
            default: s = 0;
        endcase
        if (b.kind == fpa_pkg::KIND_MUL ||
                (b.kind == fpa_pkg::KIND_DIV && sb != 0)) begin
            if (p > (neg ? 128'h8000_0000 : 128'h7fff_ffff)) begin
                p = neg ? 128'h8000_0000 : 128'h7fff_ffff;
                r.saturated = 1'b1;
            end
            s = neg ? -longint'(p[63:0]) : longint'(p[63:0]);
        end
        if (s > 64'sh7fff_ffff) begin
            s = 64'sh7fff_ffff;
            r.saturated = 1'b1;
        end else if (s < -64'sh8000_0000) begin
            s = -64'sh8000_0000;
            r.saturated = 1'b1;
        end
        r.value = s[31:0];
        return r;
    endfunction

    function void note_input(fpa_pkg::t_in_beat b);
        pending.push_back(compute(b));
    endfunction

    function void check_result(fpa_pkg::t_out_beat got);
        fpa_pkg::t_out_beat exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        checked++;
        if (got !== exp) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp, got);
            errors++;
        end
    endfunction
endclass

module testbench;
    import fpa_pkg::*;

    localparam int N_ITEMS = 1550;
    localparam int LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    t_in_beat i_data = '0;
    logic o_stall, o_valid;
    t_out_beat o_data;

    alu_scoreboard sb = new();
    int sent = 0;
    int cycles = 0;
    bit quiet = 0;
    bit hold_long = 0;

    fixed_point_alu_q24_8_core dut (.*);

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
        if (i_rst_n && i_valid && !o_stall) sb.note_input(i_data);
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
    end

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000 + $urandom_range(0, 3);
            1: return 32'h7fff_ffff - $urandom_range(0, 3);
            2: return $urandom_range(0, 3) - 1;
            3: return 32'($signed($urandom_range(0, 4000)) - 2000);
            4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_beat(t_in_beat b);
        int gap;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 9);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // receiver: random stall bursts, one long hold-off early in the run
    initial begin
        int n;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_stall <= 1'b1;
                repeat (150) @(negedge i_clk);
                hold_long = 0;
                i_stall <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 9);
                i_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_in_beat b;
        logic [31:0] edges[6];
        edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                  32'h0000_0100, 32'hffff_ff00};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        for (int k = 0; k <= 15; k++) begin
            b.kind = 4'(k);
            b.operand_a = edges[k % 6];
            b.operand_b = edges[(k + 1) % 6];
            send_beat(b);
        end
        b.kind = KIND_DIV; b.operand_a = 32'h100; b.operand_b = 0; send_beat(b);
        b.kind = KIND_INC; b.operand_a = WMAX; send_beat(b);
        b.kind = KIND_DEC; b.operand_a = WMIN; send_beat(b);
        b.kind = KIND_MIN; b.operand_a = 5; b.operand_b = 5; send_beat(b);
        b.kind = KIND_MUL; b.operand_a = 32'h180; b.operand_b = 32'h1; send_beat(b);
        b.kind = KIND_MUL; b.operand_a = 32'hffff_fe80; b.operand_b = 32'h1; send_beat(b);
        b.kind = KIND_DIV; b.operand_a = 1; b.operand_b = 32'h200; send_beat(b);
        b.kind = KIND_DIV; b.operand_a = WMIN; b.operand_b = 32'hffff_ffff; send_beat(b);
        hold_long = 1;
        for (int k = 0; k < N_ITEMS; k++) begin
            if (k > N_ITEMS - 200) quiet = 1;
            b.kind = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(10, 15))
                                                  : 4'($urandom_range(0, 9));
            b.operand_a = pick_operand();
            b.operand_b = ($urandom_range(0, 9) == 0) ? b.operand_a : pick_operand();
            send_beat(b);
        end
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("Sent %0d beats across all ten operations plus unused codes,", sent);
        $display("checked %0d results under random gaps and output stalls.", sb.checked);
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
